[rtl/fps_pkg.sv]
// Shared constants and types for the framed packet sender.
// Used by the register block, the payload memory, the sequencer and the top level.
package fps_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int HEADER_LEN  = 2;
   localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

   // Register indexes
   localparam logic REG_HEADER    = 1'b0;
   localparam logic REG_TRY_LIMIT = 1'b1;

   localparam logic [3:0] TRY_LIMIT_RESET = 4'd6;

   // Request commands
   localparam logic CMD_PAYLOAD = 1'b0;
   localparam logic CMD_REPLY   = 1'b1;

   // Packet phases
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_COLLECT = 2'd1;
   localparam logic [1:0] PH_AWAIT   = 2'd2;

   localparam logic [7:0] ACK_BYTE = 8'h00;

   typedef struct packed {
      logic [15:0] header_bytes;
      logic [3:0]  try_limit;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

endpackage

[rtl/fps_payload_ram.sv]
// Payload store: one write port and one registered read port, read data in the next cycle.
// Depends on fps_pkg for the depth and the write port struct.
module fps_payload_ram import fps_pkg::*; (
   input  logic              clock,
   input  ram_wr_type        wr,
   input  logic [ADDR_W-1:0] raddr,
   output logic [7:0]        rdata
);

   logic [7:0] payload_mem [MAX_PAYLOAD];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         payload_mem[wr.addr] <= wr.data;
      end
      rdata_ff <= payload_mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/fps_csr.sv]
// APB-style configuration registers: frame header bytes and try limit.
// Depends on fps_pkg for register indexes and the configuration struct.
module fps_csr import fps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic [15:0] header_ff;
   logic [15:0] header_in;
   logic [3:0]  try_limit_ff;
   logic [3:0]  try_limit_in;
   logic        wr_en;
   logic        reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      header_in    = header_ff;
      try_limit_in = try_limit_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_HEADER:    header_in    = pwdata[15:0];
            REG_TRY_LIMIT: try_limit_in = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_HEADER:    prdata = {16'd0, header_ff};
         REG_TRY_LIMIT: prdata = {28'd0, try_limit_ff};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= 16'd0;
         try_limit_ff <= TRY_LIMIT_RESET;
      end else begin
         header_ff    <= header_in;
         try_limit_ff <= try_limit_in;
      end
   end

   assign cfg.header_bytes = header_ff;
   assign cfg.try_limit    = try_limit_ff;

endmodule

[rtl/fps_seq.sv]
// Packet sequencer: request decode, checksum and retry state, byte emission.
// Depends on fps_pkg; reads and writes the payload memory through its ports.
module fps_seq import fps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [7:0]        req_packet_id,
   input  logic              req_confirm,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   output ram_wr_type        ram_wr,
   output logic [ADDR_W-1:0] ram_raddr,
   input  logic [7:0]        ram_rdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_is_done,
   output logic              rsp_success,
   output logic              rsp_last
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_HEAD1  = 4'd1;
   localparam logic [3:0] ST_HEAD0  = 4'd2;
   localparam logic [3:0] ST_PID    = 4'd3;
   localparam logic [3:0] ST_DATA   = 4'd4;
   localparam logic [3:0] ST_REPLAY = 4'd5;
   localparam logic [3:0] ST_SUML   = 4'd6;
   localparam logic [3:0] ST_SUMH   = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;
   localparam logic [3:0] ST_HEAD_FIRST = (HEADER_LEN == 2) ? ST_HEAD1 : ST_HEAD0;

   logic [3:0]        step_ff, step_in, step_nxt;
   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        sum_low_ff, sum_low_in;
   logic [7:0]        sum_high_ff, sum_high_in;
   logic [7:0]        pid_ff, pid_in;
   logic              conf_ff, conf_in;
   logic [3:0]        tries_ff, tries_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [7:0]        data_ff, data_in;
   logic              has_data_ff, has_data_in;
   logic              has_tail_ff, has_tail_in;
   logic              has_done_ff, has_done_in;
   logic              ok_ff, ok_in;
   logic              replay_ff, replay_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_tx_ff, rsp_tx_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              out_free;
   logic              emitting;
   logic              start;
   logic              store;
   logic [CNT_W-1:0]  cnt_base;
   logic [7:0]        sl_base, sh_base, sl_new;
   logic              conf_new;
   logic [3:0]        limit;
   logic              replay_end;
   logic [7:0]        emit_byte;

   assign req_stall = (step_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emitting  = (step_ff != ST_IDLE) && out_free;

   assign replay_end = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // Request decode terms
   assign start    = (phase_ff == PH_IDLE);
   assign cnt_base = start ? '0 : count_ff;
   assign sl_base  = start ? 8'd0 : sum_low_ff;
   assign sh_base  = start ? 8'd0 : sum_high_ff;
   assign store    = cnt_base < CNT_W'(MAX_PAYLOAD);
   assign sl_new   = sl_base + req_data_byte;
   assign conf_new = start ? req_confirm : conf_ff;
   assign limit    = (cfg.try_limit == 4'd0) ? 4'd1 : cfg.try_limit;

   // Step that follows the current one
   always_comb begin
      case (step_ff)
         ST_HEAD1: step_nxt = ST_HEAD0;
         ST_HEAD0: step_nxt = ST_PID;
         ST_PID: begin
            if (replay_ff)        step_nxt = ST_REPLAY;
            else if (has_data_ff) step_nxt = ST_DATA;
            else if (has_tail_ff) step_nxt = ST_SUML;
            else if (has_done_ff) step_nxt = ST_DONE;
            else                  step_nxt = ST_IDLE;
         end
         ST_DATA: begin
            if (has_tail_ff)      step_nxt = ST_SUML;
            else if (has_done_ff) step_nxt = ST_DONE;
            else                  step_nxt = ST_IDLE;
         end
         ST_REPLAY: step_nxt = replay_end ? ST_SUML : ST_REPLAY;
         ST_SUML:   step_nxt = ST_SUMH;
         ST_SUMH:   step_nxt = has_done_ff ? ST_DONE : ST_IDLE;
         default:   step_nxt = ST_IDLE;
      endcase
   end

   always_comb begin
      case (step_ff)
         ST_HEAD1:  emit_byte = cfg.header_bytes[15:8];
         ST_HEAD0:  emit_byte = cfg.header_bytes[7:0];
         ST_PID:    emit_byte = pid_ff;
         ST_DATA:   emit_byte = data_ff;
         ST_REPLAY: emit_byte = ram_rdata;
         ST_SUML:   emit_byte = sum_low_ff;
         ST_SUMH:   emit_byte = sum_high_ff;
         default:   emit_byte = 8'd0;
      endcase
   end

   always_comb begin
      step_in     = step_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      sum_low_in  = sum_low_ff;
      sum_high_in = sum_high_ff;
      pid_in      = pid_ff;
      conf_in     = conf_ff;
      tries_in    = tries_ff;
      idx_in      = idx_ff;
      data_in     = data_ff;
      has_data_in = has_data_ff;
      has_tail_in = has_tail_ff;
      has_done_in = has_done_ff;
      ok_in       = ok_ff;
      replay_in   = replay_ff;
      ram_wr.en   = 1'b0;
      ram_wr.addr = cnt_base[ADDR_W-1:0];
      ram_wr.data = req_data_byte;

      rsp_valid_in = rsp_valid_ff;
      rsp_tx_in    = rsp_tx_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept) begin
         if (req_command == CMD_PAYLOAD) begin
            if (phase_ff != PH_AWAIT) begin
               pid_in      = start ? req_packet_id : pid_ff;
               conf_in     = conf_new;
               count_in    = cnt_base;
               sum_low_in  = sl_base;
               sum_high_in = sh_base;
               tries_in    = start ? 4'd0 : tries_ff;
               phase_in    = PH_COLLECT;
               data_in     = req_data_byte;
               if (store) begin
                  ram_wr.en   = 1'b1;
                  count_in    = cnt_base + CNT_W'(1);
                  sum_low_in  = sl_new;
                  sum_high_in = sh_base + sl_new;
               end
               // Closing byte: send the check bytes, then wait or report
               if (req_last_byte) begin
                  tries_in = 4'd1;
                  phase_in = conf_new ? PH_AWAIT : PH_IDLE;
               end
               has_data_in = store;
               has_tail_in = req_last_byte;
               has_done_in = req_last_byte && !conf_new;
               ok_in       = 1'b1;
               replay_in   = 1'b0;
               if (start)              step_in = ST_HEAD_FIRST;
               else if (store)         step_in = ST_DATA;
               else if (req_last_byte) step_in = ST_SUML;
               else                    step_in = ST_IDLE;
            end
         end else if (phase_ff == PH_AWAIT) begin
            has_data_in = 1'b0;
            if (req_data_byte == ACK_BYTE) begin
               has_tail_in = 1'b0;
               has_done_in = 1'b1;
               ok_in       = 1'b1;
               replay_in   = 1'b0;
               phase_in    = PH_IDLE;
               step_in     = ST_DONE;
            end else if (tries_ff >= limit) begin
               has_tail_in = 1'b0;
               has_done_in = 1'b1;
               ok_in       = 1'b0;
               replay_in   = 1'b0;
               phase_in    = PH_IDLE;
               step_in     = ST_DONE;
            end else begin
               // Resend the whole frame from the store
               has_tail_in = 1'b1;
               has_done_in = 1'b0;
               replay_in   = 1'b1;
               idx_in      = '0;
               tries_in    = tries_ff + 4'd1;
               step_in     = ST_HEAD_FIRST;
            end
         end
      end

      if (emitting) begin
         rsp_valid_in = 1'b1;
         rsp_tx_in    = emit_byte;
         rsp_done_in  = (step_ff == ST_DONE);
         rsp_ok_in    = (step_ff == ST_DONE) && ok_ff;
         rsp_last_in  = (step_nxt == ST_IDLE);
         step_in      = step_nxt;
         if (step_ff == ST_REPLAY) begin
            idx_in = idx_ff + ADDR_W'(1);
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // The read address follows the next index, so the registered read data
   // always belongs to idx_ff. Stores land only while the sequencer is idle,
   // long before a replay reads them back.
   assign ram_raddr = idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         sum_low_ff   <= 8'd0;
         sum_high_ff  <= 8'd0;
         pid_ff       <= 8'd0;
         conf_ff      <= 1'b0;
         tries_ff     <= 4'd0;
         idx_ff       <= '0;
         has_data_ff  <= 1'b0;
         has_tail_ff  <= 1'b0;
         has_done_ff  <= 1'b0;
         ok_ff        <= 1'b0;
         replay_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_low_ff   <= sum_low_in;
         sum_high_ff  <= sum_high_in;
         pid_ff       <= pid_in;
         conf_ff      <= conf_in;
         tries_ff     <= tries_in;
         idx_ff       <= idx_in;
         has_data_ff  <= has_data_in;
         has_tail_ff  <= has_tail_in;
         has_done_ff  <= has_done_in;
         ok_ff        <= ok_in;
         replay_ff    <= replay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      rsp_tx_ff   <= rsp_tx_in;
      rsp_done_ff <= rsp_done_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tx_byte = rsp_tx_ff;
   assign rsp_is_done = rsp_done_ff;
   assign rsp_success = rsp_ok_ff;
   assign rsp_last    = rsp_last_ff;

   a_await_confirmed: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_AWAIT |-> conf_ff && tries_ff != 4'd0)
      else $error("awaiting a reply without a confirmed, sent frame");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PAYLOAD))
      else $error("payload count beyond store depth");

   a_no_write_in_replay: assert property (@(posedge clock) disable iff (reset)
      step_ff == ST_REPLAY |-> !ram_wr.en)
      else $error("store written during replay");

   a_replay_has_data: assert property (@(posedge clock) disable iff (reset)
      step_ff == ST_REPLAY |-> count_ff != '0)
      else $error("replay of an empty payload");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_last_ff && rsp_tx_ff == 8'd0)
      else $error("completion report not closing its request");

endmodule

[rtl/framed_packet_sender_with_ack_retry.sv]
// Framed packet sender with reply-driven retry: top level.
// A taken request sets the step register; its first result then moves to the output register.
// One result per cycle while the output is free; no new request until the last is registered.
// A resend emits HEADER_LEN + 3 + payload length bytes, the payload read back from its memory.
// Reset is synchronous: phase, counters, sums, flags and settings return to defaults; payload
// memory is not cleared, since only bytes written for the current packet are read back.
module framed_packet_sender_with_ack_retry import fps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_packet_id,
   input  logic        req_confirm,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_is_done,
   output logic        rsp_success,
   output logic        rsp_last,
   // Configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type           cfg;
   ram_wr_type        ram_wr;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   // Header and try limit registers
   fps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Payload kept for resends; written as bytes arrive, read back during a resend
   fps_payload_ram u_ram (
      .clock (clock),
      .wr    (ram_wr),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Decode each request, hold checksum and retry state, and emit one byte per cycle into the
   // output register while it is free; the next request is taken while the last result waits.
   fps_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_packet_id (req_packet_id),
      .req_confirm   (req_confirm),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .ram_wr        (ram_wr),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_is_done   (rsp_is_done),
      .rsp_success   (rsp_success),
      .rsp_last      (rsp_last)
   );

endmodule

[dv/testbench.sv]
// Self-checking testbench for the framed packet sender with reply-driven retry.
// Depends on fps_pkg and on the framed_packet_sender_with_ack_retry top level only.
module testbench import fps_pkg::*;;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_GAP       = 10;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       is_done;
      logic       success;
      logic       last;
   } link_result_type;

   // Track the sender's state and hold the link bytes and completion
   // reports that are still owed.
   class link_scoreboard;
      link_result_type  owed[$];
      logic [15:0]      header_bytes = 16'h0000;
      logic [3:0]       try_limit    = TRY_LIMIT_RESET;
      logic [7:0]       payload_mem[MAX_PAYLOAD];
      logic [CNT_W-1:0] payload_len  = '0;
      logic [7:0]       sum_lo       = '0;
      logic [7:0]       sum_hi       = '0;
      logic [7:0]       held_id      = '0;
      logic             held_confirm = 1'b0;
      logic [3:0]       tries        = '0;
      logic [1:0]       phase        = PH_IDLE;
      int               mismatches   = 0;

      task report(string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      function void set_register(logic idx, logic [31:0] value);
         if (idx == REG_HEADER) header_bytes = value[15:0];
         else try_limit = value[3:0];
      endfunction

      function void owe(logic [7:0] b, logic done, logic ok);
         link_result_type r;
         r.tx_byte = b;
         r.is_done = done;
         r.success = ok;
         r.last    = 1'b0;
         owed.push_back(r);
      endfunction

      function void owe_head();
         for (int i = HEADER_LEN - 1; i >= 0; i--)
            owe(header_bytes[8*(i & 1) +: 8], 1'b0, 1'b0);
         owe(held_id, 1'b0, 1'b0);
      endfunction

      function void owe_tail();
         owe(sum_lo, 1'b0, 1'b0);
         owe(sum_hi, 1'b0, 1'b0);
      endfunction

      // Return 0 when the request is ignored outright.
      function bit take_request(logic cmd, logic [7:0] pid, logic conf,
                                logic [7:0] data, logic lastb);
         int         start;
         logic [3:0] limit;
         start = owed.size();
         if (cmd == CMD_PAYLOAD) begin
            if (phase == PH_AWAIT) return 1'b0;
            if (phase == PH_IDLE) begin
               held_id      = pid;
               held_confirm = conf;
               payload_len  = '0;
               sum_lo       = '0;
               sum_hi       = '0;
               tries        = '0;
               phase        = PH_COLLECT;
               owe_head();
            end
            if (payload_len < MAX_PAYLOAD) begin
               payload_mem[payload_len[ADDR_W-1:0]] = data;
               payload_len = payload_len + 1'b1;
               sum_lo = sum_lo + data;
               sum_hi = sum_hi + sum_lo;
               owe(data, 1'b0, 1'b0);
            end
            if (lastb) begin
               owe_tail();
               tries = 4'd1;
               if (held_confirm) begin
                  phase = PH_AWAIT;
               end else begin
                  owe(8'h00, 1'b1, 1'b1);
                  phase = PH_IDLE;
               end
            end
         end else begin
            limit = (try_limit == 4'd0) ? 4'd1 : try_limit;
            if (phase != PH_AWAIT) return 1'b0;
            if (data == ACK_BYTE) begin
               owe(8'h00, 1'b1, 1'b1);
               phase = PH_IDLE;
            end else if (tries >= limit) begin
               owe(8'h00, 1'b1, 1'b0);
               phase = PH_IDLE;
            end else begin
               owe_head();
               for (int i = 0; i < payload_len; i++) owe(payload_mem[i], 1'b0, 1'b0);
               owe_tail();
               tries = tries + 4'd1;
            end
         end
         if (owed.size() > start) owed[owed.size() - 1].last = 1'b1;
         return 1'b1;
      endfunction

      task check_output(link_result_type got);
         link_result_type want;
         if (owed.size() == 0) begin
            report($sformatf("unexpected result tx_byte=%02h is_done=%b success=%b last=%b",
                             got.tx_byte, got.is_done, got.success, got.last));
            return;
         end
         want = owed.pop_front();
         if (got.tx_byte !== want.tx_byte)
            report($sformatf("tx_byte got %02h want %02h", got.tx_byte, want.tx_byte));
         if (got.is_done !== want.is_done)
            report($sformatf("is_done got %b want %b", got.is_done, want.is_done));
         if (got.success !== want.success)
            report($sformatf("success got %b want %b", got.success, want.success));
         if (got.last !== want.last)
            report($sformatf("last got %b want %b", got.last, want.last));
      endtask
   endclass

   // Clock, reset and every block input start at known values.
   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic        req_command   = CMD_PAYLOAD;
   logic [7:0]  req_packet_id = 8'h00;
   logic        req_confirm   = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_is_done;
   logic        rsp_success;
   logic        rsp_last;
   logic        psel          = 1'b0;
   logic        penable       = 1'b0;
   logic        pwrite        = 1'b0;
   logic [2:0]  paddr         = 3'd0;
   logic [31:0] pwdata        = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   link_scoreboard sb = new();
   int cycle_count     = 0;
   int effective_items = 0;
   bit quiet           = 1'b0;  // suppress idling on both sides

   framed_packet_sender_with_ack_retry u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Abort a hung run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[framed_packet_sender_with_ack_retry] ERROR");
      $finish;
   end

   // Compare every accepted result; values read here are the pre-edge ones.
   always @(posedge clock) begin
      link_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.tx_byte = rsp_tx_byte;
         got.is_done = rsp_is_done;
         got.success = rsp_success;
         got.last    = rsp_last;
         sb.check_output(got);
      end
   end

   // Stall the result channel for a random gap before each result.
   initial begin
      int hold;
      forever begin
         hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Drive one request after a random gap and hold it until it is taken.
   // Keep valid high across back-to-back requests.
   task automatic send_request(input logic cmd, input logic [7:0] pid, input logic conf,
                               input logic [7:0] data, input logic lastb);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_packet_id <= pid;
      req_confirm   <= conf;
      req_data_byte <= data;
      req_last_byte <= lastb;
      do @(posedge clock); while (req_stall);
      if (sb.take_request(cmd, pid, conf, data, lastb)) effective_items++;
   endtask

   // Send a request whose packet id and confirm flag are random.
   task automatic send_byte(input logic cmd, input logic [7:0] data, input logic lastb);
      send_request(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), data, lastb);
   endtask

   // Answer an awaiting packet: a few rejects, sometimes enough to exhaust the
   // tries, then an acknowledge; sprinkle in payload bytes the block must drop.
   task automatic answer_packet();
      int rejects;
      if (sb.phase != PH_AWAIT) return;
      rejects = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(0, 3);
      while (sb.phase == PH_AWAIT) begin
         if ($urandom_range(0, 7) == 0) begin
            send_byte(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (rejects > 0) begin
            send_byte(CMD_REPLY, 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
            rejects--;
         end else begin
            send_byte(CMD_REPLY, ACK_BYTE, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic send_packet(input int len);
      for (int i = 0; i < len; i++)
         send_byte(CMD_PAYLOAD, 8'($urandom_range(0, 255)), i == len - 1);
      answer_packet();
   endtask

   // Mostly whole packets with random content; the rest stray replies and
   // fully random requests. Close any open packet before returning.
   task automatic run_traffic(input int target);
      int start;
      int pick;
      start = effective_items;
      while (effective_items - start < target) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            end
            1: begin
               send_byte(CMD_REPLY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            default: begin
               // Long packets may run past the store and exercise the drop of extra bytes.
               send_packet(($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                       : $urandom_range(1, 8));
            end
         endcase
      end
      if (sb.phase == PH_COLLECT) send_byte(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 1'b1);
      answer_packet();
   endtask

   // Drop valid, wait for every owed result, then let the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write a register, then read it back through the same port.
   task automatic csr_write(input logic idx, input logic [31:0] value);
      logic [31:0] mask;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      mask = (idx == REG_HEADER) ? 32'h0000_FFFF : 32'h0000_000F;
      if ((prdata & mask) !== (value & mask))
         sb.report($sformatf("register %0d read %08h want %08h", idx, prdata & mask,
                             value & mask));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a stray reply, then an unconfirmed two-byte packet.
      send_request(CMD_REPLY,   8'h00, 1'b0, ACK_BYTE, 1'b0);
      send_request(CMD_PAYLOAD, 8'hFF, 1'b0, 8'hFF,    1'b0);
      send_request(CMD_PAYLOAD, 8'h00, 1'b1, 8'h00,    1'b1);
      settle();
      csr_write(REG_HEADER,    32'h0000_5AA5);
      csr_write(REG_TRY_LIMIT, 32'd2);

      // Confirmed packet: a busy-host byte, one resend, then the tries run out.
      send_request(CMD_PAYLOAD, 8'h81, 1'b1, 8'h00, 1'b0);
      send_request(CMD_PAYLOAD, 8'h00, 1'b0, 8'h7F, 1'b0);
      send_request(CMD_PAYLOAD, 8'h00, 1'b0, 8'hFF, 1'b1);
      send_request(CMD_PAYLOAD, 8'h42, 1'b0, 8'h55, 1'b1);
      send_request(CMD_REPLY,   8'h00, 1'b0, 8'h01, 1'b0);
      send_request(CMD_REPLY,   8'hFF, 1'b1, 8'hFF, 1'b1);

      // Single-byte confirmed packet: one resend, then acknowledged.
      send_request(CMD_PAYLOAD, 8'h3C, 1'b1, 8'h80,    1'b1);
      send_request(CMD_REPLY,   8'h00, 1'b0, 8'h80,    1'b0);
      send_request(CMD_REPLY,   8'h00, 1'b0, ACK_BYTE, 1'b0);
      send_request(CMD_REPLY,   8'h00, 1'b0, 8'h01,    1'b0);
      settle();

      // A try limit of zero fails on the first reject.
      csr_write(REG_TRY_LIMIT, 32'd0);
      send_request(CMD_PAYLOAD, 8'hA5, 1'b1, 8'h01, 1'b1);
      send_request(CMD_REPLY,   8'h00, 1'b0, 8'hFE, 1'b0);
      settle();

      // Random traffic under several settings, the extremes first.
      csr_write(REG_HEADER,    32'h0000_FFFF);
      csr_write(REG_TRY_LIMIT, 32'd15);
      run_traffic(40);
      settle();
      csr_write(REG_HEADER,    32'h0000_0000);
      csr_write(REG_TRY_LIMIT, 32'd1);
      run_traffic(40);
      settle();
      quiet = 1'b1;
      csr_write(REG_HEADER,    $urandom);
      csr_write(REG_TRY_LIMIT, $urandom_range(1, 15));
      run_traffic(40);
      settle();
      quiet = 1'b0;
      csr_write(REG_HEADER,    $urandom);
      csr_write(REG_TRY_LIMIT, $urandom_range(2, 14));
      run_traffic(40);
      settle();

      if (sb.mismatches == 0) begin
         $display("[framed_packet_sender_with_ack_retry] OK");
      end else begin
         $display("[framed_packet_sender_with_ack_retry] ERROR");
      end
      $finish;
   end

endmodule
